[rtl/iacl_pkg.sv]
// ignition advance curve lookup: shared types, curve table and sizing constants
// used by every module of the block; depends on nothing
package iacl_pkg;

  localparam int SPEED_W      = 16;
  localparam int ADV_W        = 12;
  localparam int LIMIT_W      = 16;
  localparam int CURVE_POINTS = 16;
  localparam int SEGMENTS     = CURVE_POINTS - 1;
  localparam int SEG_W        = $clog2(CURVE_POINTS);
  localparam int TOP_SPEED    = 16000;

  localparam int FRAC_W              = 17;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES = (FRAC_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
  localparam int PROD_W     = ADV_W + FRAC_W;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_CRANKING_ADVANCE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOP_ADVANCE          = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRANKING_SPEED_LIMIT = 2'd2;

  localparam logic [ADV_W-1:0]   CRANKING_ADVANCE_RESET = 12'd50;
  localparam logic [ADV_W-1:0]   TOP_ADVANCE_RESET      = 12'd350;
  localparam logic [LIMIT_W-1:0] CRANKING_LIMIT_RESET   = 16'd500;

  typedef logic [ADV_W-1:0] adv_t;

  localparam adv_t ADVANCE_CURVE [CURVE_POINTS] = '{
    12'd50,  12'd60,  12'd80,  12'd100, 12'd130, 12'd160, 12'd190, 12'd220,
    12'd250, 12'd280, 12'd300, 12'd320, 12'd335, 12'd345, 12'd350, 12'd350
  };

  typedef enum logic [1:0] {
    REGION_CRANK = 2'd0,
    REGION_CURVE = 2'd1,
    REGION_TOP   = 2'd2
  } region_t;

  // fields that ride alongside the fraction divider
  typedef struct packed {
    region_t region;
    adv_t    lo_adv;
    adv_t    diff;
  } side_t;

endpackage

[rtl/iacl_seg.sv]
// ignition advance curve lookup: region decision and curve segment selection
// two register stages; depends on iacl_pkg
module iacl_seg import iacl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [SPEED_W-1:0] speed,
  input  logic [LIMIT_W-1:0] crank_limit,
  output logic               out_valid,
  output side_t              out_side,
  output logic [SPEED_W-1:0] out_delta,
  output logic [SPEED_W-1:0] out_width
);

  logic [SPEED_W-1:0] thresh [SEGMENTS];
  logic [SPEED_W-1:0] bound  [CURVE_POINTS];

  // thresh[i] is the first speed that falls in segment i
  assign thresh[0] = '0;
  for (genvar g = 1; g < SEGMENTS; g++) begin : g_thresh
    localparam int Thr = (g * TOP_SPEED + SEGMENTS - 1) / SEGMENTS;
    assign thresh[g] = SPEED_W'(Thr);
  end

  for (genvar g = 0; g < CURVE_POINTS; g++) begin : g_bound
    localparam int Bnd = (g * TOP_SPEED) / SEGMENTS;
    assign bound[g] = SPEED_W'(Bnd);
  end

  // stage a: compares against every segment start
  logic                  a_valid;
  region_t               a_region;
  logic [SEGMENTS-1:1]   a_therm;
  logic [SPEED_W-1:0]    a_speed;
  region_t               a_region_next;
  logic [SEGMENTS-1:1]   a_therm_next;

  always_comb begin
    if (speed < crank_limit) begin
      a_region_next = REGION_CRANK;
    end else if (speed >= SPEED_W'(TOP_SPEED)) begin
      a_region_next = REGION_TOP;
    end else begin
      a_region_next = REGION_CURVE;
    end
    for (int i = 1; i < SEGMENTS; i++) begin
      a_therm_next[i] = (speed >= thresh[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_region <= a_region_next;
      a_therm  <= a_therm_next;
      a_speed  <= speed;
    end
  end

  // stage b: segment bounds, curve points and divider operands
  logic [SEG_W-1:0]   seg;
  logic [SEG_W-1:0]   nxt;
  logic [SPEED_W-1:0] lo;
  logic [SPEED_W-1:0] width_next;
  adv_t               lo_adv;
  adv_t               hi_adv;
  side_t              side_next;

  always_comb begin
    seg = '0;
    for (int i = 1; i < SEGMENTS; i++) begin
      if (a_therm[i]) begin
        seg = SEG_W'(i);
      end
    end
    nxt        = seg + 1'b1;
    lo         = bound[seg];
    width_next = bound[nxt] - lo;
    lo_adv     = ADVANCE_CURVE[seg];
    hi_adv     = ADVANCE_CURVE[nxt];
    side_next.region = a_region;
    side_next.lo_adv = lo_adv;
    // empty segment or falling curve adds nothing
    if (hi_adv >= lo_adv && width_next != '0) begin
      side_next.diff = hi_adv - lo_adv;
    end else begin
      side_next.diff = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side  <= side_next;
      out_delta <= a_speed - lo;
      out_width <= width_next;
    end
  end

  a_therm_ordered: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> ((a_therm & (a_therm + 1'b1)) == '0))
    else $error("segment compares not a thermometer code");

  b_delta_in_segment: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_side.region == REGION_CURVE |-> out_delta <= out_width)
    else $error("speed lies beyond its segment");

endmodule

[rtl/iacl_div.sv]
// ignition advance curve lookup: pipelined restoring divider for the
// 17-bit interpolation fraction; depends on iacl_pkg
module iacl_div import iacl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  side_t              in_side,
  input  logic [SPEED_W-1:0] delta,
  input  logic [SPEED_W-1:0] width,
  output logic               out_valid,
  output side_t              out_side,
  output logic [FRAC_W-1:0]  quot
);

  logic               stg_valid [DIV_STAGES];
  side_t              stg_side  [DIV_STAGES];
  logic [SPEED_W:0]   stg_rem   [DIV_STAGES];
  logic [FRAC_W-1:0]  stg_quo   [DIV_STAGES];
  logic [SPEED_W-1:0] stg_div   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic               prev_valid;
    side_t              prev_side;
    logic [SPEED_W:0]   prev_rem;
    logic [FRAC_W-1:0]  prev_quo;
    logic [SPEED_W-1:0] prev_div;
    logic [SPEED_W:0]   rem_next;
    logic [FRAC_W-1:0]  quo_next;

    if (s == 0) begin : g_first
      assign prev_valid = in_valid;
      assign prev_side  = in_side;
      assign prev_rem   = {1'b0, delta};
      assign prev_quo   = '0;
      assign prev_div   = width;
    end else begin : g_rest
      assign prev_valid = stg_valid[s-1];
      assign prev_side  = stg_side[s-1];
      assign prev_rem   = stg_rem[s-1];
      assign prev_quo   = stg_quo[s-1];
      assign prev_div   = stg_div[s-1];
    end

    // for curve speeds the remainder stays below the divisor, so the shift never drops a bit
    always_comb begin
      int j;
      rem_next = prev_rem;
      quo_next = prev_quo;
      for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
        j = s * DIV_STEPS_PER_STAGE + k;
        if (j < FRAC_W) begin
          if (j != 0) begin
            rem_next = {rem_next[SPEED_W-1:0], 1'b0};
          end
          if (rem_next >= {1'b0, prev_div}) begin
            rem_next = rem_next - {1'b0, prev_div};
            quo_next = {quo_next[FRAC_W-2:0], 1'b1};
          end else begin
            quo_next = {quo_next[FRAC_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg_valid[s] <= 1'b0;
      end else if (en) begin
        stg_valid[s] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_side[s] <= prev_side;
        stg_rem[s]  <= rem_next;
        stg_quo[s]  <= quo_next;
        stg_div[s]  <= prev_div;
      end
    end
  end

  assign out_valid = stg_valid[DIV_STAGES-1];
  assign out_side  = stg_side[DIV_STAGES-1];
  assign quot      = stg_quo[DIV_STAGES-1];

  quot_at_most_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_side.region == REGION_CURVE |->
      !(quot[FRAC_W-1] && (quot[FRAC_W-2:0] != '0)))
    else $error("interpolation fraction above one");

endmodule

[rtl/iacl_blend.sv]
// ignition advance curve lookup: scales the curve step by the fraction and
// picks the final advance per region; depends on iacl_pkg
module iacl_blend import iacl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [FRAC_W-1:0] quot,
  input  adv_t              crank_adv,
  input  adv_t              top_adv,
  output logic              out_valid,
  output adv_t              spark_advance,
  output logic [1:0]        speed_region
);

  logic              m_valid;
  region_t           m_region;
  adv_t              m_lo_adv;
  logic [PROD_W-1:0] m_prod;
  adv_t              adv_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_region <= in_side.region;
      m_lo_adv <= in_side.lo_adv;
      m_prod   <= PROD_W'(in_side.diff) * PROD_W'(quot);
    end
  end

  always_comb begin
    case (m_region)
      REGION_CRANK: adv_next = crank_adv;
      REGION_TOP:   adv_next = top_adv;
      REGION_CURVE: adv_next = m_lo_adv + m_prod[FRAC_W-1+ADV_W-1:FRAC_W-1];
      default:      adv_next = m_lo_adv;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spark_advance <= adv_next;
      speed_region  <= m_region;
    end
  end

endmodule

[rtl/ignition_advance_curve_lookup.sv]
// Spark advance lookup from engine speed over a fixed 16-point curve.
// Takes one speed per cycle while in_stall is low and returns one advance per
// speed, in order: two stages of region and segment selection, a 9-stage divider
// that makes two bits of the interpolation fraction per stage (one in the last),
// and two stages of multiply and final select, 13 register stages in all. A
// one-entry skid register in front holds a request taken while the pipeline is
// frozen and is bypassed otherwise. A stall on a valid output freezes the whole
// pipeline; the input stall is raised once the skid register has filled with such
// a request. Configuration registers are read as the item passes, so write them
// only while the pipeline is empty. Depends on iacl_pkg, iacl_seg, iacl_div,
// iacl_blend.
module ignition_advance_curve_lookup import iacl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   write_enable,
  input  logic [CFG_INDEX_W-1:0] write_index,
  input  logic [CFG_DATA_W-1:0]  write_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SPEED_W-1:0]     engine_speed,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ADV_W-1:0]       spark_advance,
  output logic [1:0]             speed_region
);

  adv_t               cranking_advance;
  adv_t               top_advance;
  logic [LIMIT_W-1:0] cranking_speed_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cranking_advance     <= CRANKING_ADVANCE_RESET;
      top_advance          <= TOP_ADVANCE_RESET;
      cranking_speed_limit <= CRANKING_LIMIT_RESET;
    end else if (write_enable) begin
      case (write_index)
        CFG_CRANKING_ADVANCE:     cranking_advance     <= write_data[ADV_W-1:0];
        CFG_TOP_ADVANCE:          top_advance          <= write_data[ADV_W-1:0];
        CFG_CRANKING_SPEED_LIMIT: cranking_speed_limit <= write_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline moves unless a finished request is held at the output
  logic               en;
  logic               skid_full;
  logic [SPEED_W-1:0] skid_speed;
  logic               accept;
  logic               src_valid;
  logic [SPEED_W-1:0] src_speed;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = skid_full;
  assign accept    = in_valid && !skid_full;
  assign src_valid = skid_full || in_valid;
  assign src_speed = skid_full ? skid_speed : engine_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (en) begin
      skid_full <= 1'b0;
    end else if (accept) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && accept) begin
      skid_speed <= engine_speed;
    end
  end

  logic               seg_valid;
  side_t              seg_side;
  logic [SPEED_W-1:0] seg_delta;
  logic [SPEED_W-1:0] seg_width;
  logic               div_valid;
  side_t              div_side;
  logic [FRAC_W-1:0]  div_quot;

  iacl_seg u_seg (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (src_valid),
    .speed      (src_speed),
    .crank_limit(cranking_speed_limit),
    .out_valid  (seg_valid),
    .out_side   (seg_side),
    .out_delta  (seg_delta),
    .out_width  (seg_width)
  );

  iacl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (seg_valid),
    .in_side  (seg_side),
    .delta    (seg_delta),
    .width    (seg_width),
    .out_valid(div_valid),
    .out_side (div_side),
    .quot     (div_quot)
  );

  iacl_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (div_valid),
    .in_side      (div_side),
    .quot         (div_quot),
    .crank_adv    (cranking_advance),
    .top_adv      (top_advance),
    .out_valid    (out_valid),
    .spark_advance(spark_advance),
    .speed_region (speed_region)
  );

  skid_fills_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(out_valid && out_stall))
    else $error("skid register filled while the pipeline was moving");

  skid_drains_on_move: assert property (@(posedge clk) disable iff (rst)
    skid_full && en |=> !skid_full)
    else $error("skid register kept a request the pipeline took");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// testbench for ignition_advance_curve_lookup: drives engine speeds and register writes,
// predicts each spark advance and region and checks them in order against the block
// depends on iacl_pkg and the rtl of the block
module tb_top;
  import iacl_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REGISTER = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 90;

  class advance_scoreboard;
    typedef struct packed {
      adv_t    adv;
      region_t region;
    } advance_t;

    adv_t               crank_adv;
    adv_t               top_adv;
    logic [LIMIT_W-1:0] crank_limit;
    advance_t           expected_q[$];
    int                 errors;
    int                 checked;
    int                 region_hits[3];
    int                 rounding_hits;

    function new();
      crank_adv   = CRANKING_ADVANCE_RESET;
      top_adv     = TOP_ADVANCE_RESET;
      crank_limit = CRANKING_LIMIT_RESET;
      errors = 0;
      checked = 0;
      rounding_hits = 0;
      foreach (region_hits[i]) region_hits[i] = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CRANKING_ADVANCE:     crank_adv = data[ADV_W-1:0];
        CFG_TOP_ADVANCE:          top_adv = data[ADV_W-1:0];
        CFG_CRANKING_SPEED_LIMIT: crank_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function advance_t predict(logic [SPEED_W-1:0] speed);
      advance_t r;
      longint   spd, seg, nxt, lo, hi, frac, diff;
      adv_t     lo_adv, hi_adv;
      spd = longint'(speed);
      if (speed < crank_limit) begin
        r.adv = crank_adv;
        r.region = REGION_CRANK;
      end else if (spd >= TOP_SPEED) begin
        r.adv = top_adv;
        r.region = REGION_TOP;
      end else begin
        seg = (spd * SEGMENTS) / TOP_SPEED;
        if (seg > SEGMENTS) seg = SEGMENTS;
        nxt = (seg + 1 < CURVE_POINTS) ? seg + 1 : SEGMENTS;
        lo_adv = ADVANCE_CURVE[seg];
        hi_adv = ADVANCE_CURVE[nxt];
        lo = (seg * TOP_SPEED) / SEGMENTS;
        hi = (nxt * TOP_SPEED) / SEGMENTS;
        r.region = REGION_CURVE;
        if (hi <= lo || spd < lo) begin
          r.adv = lo_adv;
        end else begin
          frac = ((spd - lo) << 16) / (hi - lo);
          diff = (hi_adv >= lo_adv) ? longint'(hi_adv) - longint'(lo_adv) : 0;
          r.adv = lo_adv + adv_t'((diff * frac) >> 16);
          if (frac == 65536) rounding_hits++;
        end
      end
      return r;
    endfunction

    function void note_speed(logic [SPEED_W-1:0] speed);
      advance_t r;
      r = predict(speed);
      region_hits[r.region]++;
      expected_q.push_back(r);
    endfunction

    function void check_result(adv_t adv, logic [1:0] region);
      advance_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request waiting: advance %0d region %0d",
                 $time, adv, region);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (adv !== exp_r.adv) begin
        $display("%0t: spark_advance mismatch: expected %0d actual %0d",
                 $time, exp_r.adv, adv);
        errors++;
      end
      if (region !== exp_r.region) begin
        $display("%0t: speed_region mismatch: expected %0d actual %0d",
                 $time, exp_r.region, region);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] write_index = '0;
  logic [CFG_DATA_W-1:0]  write_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SPEED_W-1:0]     engine_speed = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ADV_W-1:0]       spark_advance;
  logic [1:0]             speed_region;

  advance_scoreboard sb;
  bit idling = 1'b1;
  bit long_hold = 1'b0;
  int holds = 0;
  int settings = 0;

  ignition_advance_curve_lookup dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .engine_speed (engine_speed),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .spark_advance(spark_advance),
    .speed_region (speed_region)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_speed(engine_speed);
    if (!rst && out_valid && !out_stall) sb.check_result(spark_advance, speed_region);
  end

  // receiver side: random stall bursts and one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
        holds++;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_speed(input logic [SPEED_W-1:0] speed);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    engine_speed <= speed;
    do @(posedge clk); while (in_stall);
  endtask

  // one edge first so the last accepted request is already noted
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] crank,
                               input logic [CFG_DATA_W-1:0] top,
                               input logic [CFG_DATA_W-1:0] limit);
    write_reg(CFG_CRANKING_ADVANCE, crank);
    write_reg(CFG_TOP_ADVANCE, top);
    write_reg(CFG_CRANKING_SPEED_LIMIT, limit);
    // out of range index, must be ignored
    write_reg(CFG_NO_REGISTER, 16'($urandom));
    write_enable <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // curve speeds most often, plus segment bounds, region edges and full range
  function automatic logic [SPEED_W-1:0] pick_speed();
    int unsigned sel, lim, k, base;
    sel = $urandom_range(0, 99);
    lim = sb.crank_limit;
    if (sel < 30) return 16'($urandom);
    if (sel < 70) begin
      if (lim < TOP_SPEED) return 16'($urandom_range(lim, TOP_SPEED - 1));
      return 16'($urandom);
    end
    if (sel < 85) begin
      k = $urandom_range(1, SEGMENTS);
      return 16'(k * TOP_SPEED / SEGMENTS + $urandom_range(0, 2) - 1);
    end
    base = $urandom_range(0, 1) ? lim : TOP_SPEED;
    return 16'(base + $urandom_range(0, 4) - 2);
  endfunction

  initial begin
    logic [SPEED_W-1:0] reset_speeds[15] = '{
      16'd0, 16'd499, 16'd500, 16'd501, 16'd1066, 16'd1067, 16'd2133, 16'd3200,
      16'd8533, 16'd14933, 16'd15999, 16'd16000, 16'd65535, 16'h5555, 16'haaaa
    };
    logic [SPEED_W-1:0] high_limit_speeds[5] = '{
      16'd15999, 16'd16000, 16'd19999, 16'd20000, 16'd65535
    };
    logic [SPEED_W-1:0] zero_limit_speeds[4] = '{16'd0, 16'd1, 16'd15999, 16'd16000};
    logic [CFG_DATA_W-1:0] crank, top, limit;
    int phase;

    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings
    foreach (reset_speeds[i]) send_speed(reset_speeds[i]);
    wait_drained();

    // cranking limit above top speed, masked upper data bits
    load_settings(16'hfe10, 16'h0000, 16'd20000);
    foreach (high_limit_speeds[i]) send_speed(high_limit_speeds[i]);
    wait_drained();

    // no cranking region at all
    load_settings(16'h0000, 16'hffff, 16'd0);
    foreach (zero_limit_speeds[i]) send_speed(zero_limit_speeds[i]);
    wait_drained();

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          crank = 16'($urandom_range(0, 3600));
          top = 16'($urandom_range(0, 3600));
          limit = 16'($urandom_range(0, 2000));
        end
        1: begin
          crank = 16'h0000;
          top = 16'd3600;
          limit = 16'd0;
        end
        2: begin
          crank = 16'd3600;
          top = 16'd0;
          limit = 16'hffff;
        end
        3: begin
          crank = 16'($urandom);
          top = 16'($urandom);
          limit = 16'($urandom);
        end
        default: begin
          crank = {4'($urandom), 12'($urandom_range(0, 3600))};
          top = {4'($urandom), 12'($urandom_range(0, 3600))};
          limit = 16'($urandom_range(0, TOP_SPEED));
        end
      endcase
      if (phase == 5) idling = 1'b0;
      load_settings(crank, top, limit);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 0 && n == 20) long_hold = 1'b1;
        if (phase == 3 && n == 45) wait_drained();
        send_speed(pick_speed());
      end
      wait_drained();
    end

    $display("%0d speeds checked: %0d cranking, %0d on the curve, %0d at top speed,",
             sb.checked, sb.region_hits[0], sb.region_hits[1], sb.region_hits[2]);
    $display("%0d at rounding edge, %0d register settings loaded, %0d long output hold-offs",
             sb.rounding_hits, settings, holds);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/iacl_pkg.sv
rtl/iacl_seg.sv
rtl/iacl_div.sv
rtl/iacl_blend.sv
rtl/ignition_advance_curve_lookup.sv
sim/tb_top.sv
